@@ hdl/rational_arithmetic_unit_defines.svh @@
// Assertion helper macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rau_pkg.sv @@
// -----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// -----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int WIDE = 64;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_DIVZERO  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // datapath operations
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;  // capture operands, form magnitudes
   localparam logic [3:0] OP_GCD_A   = 4'd2;  // start gcd on a
   localparam logic [3:0] OP_GCD_B   = 4'd3;  // start gcd on b
   localparam logic [3:0] OP_GCD_R   = 4'd4;  // start gcd on result
   localparam logic [3:0] OP_STEP    = 4'd5;  // one gcd / divide step
   localparam logic [3:0] OP_DIVN    = 4'd6;  // start num / g
   localparam logic [3:0] OP_DIVD    = 4'd7;  // start den / g
   localparam logic [3:0] OP_MUL1    = 4'd8;  // first cross products
   localparam logic [3:0] OP_MUL2    = 4'd9;  // combine into result
   localparam logic [3:0] OP_FINISH  = 4'd10; // form output

   localparam logic [1:0] TGT_A = 2'd0;
   localparam logic [1:0] TGT_B = 2'd1;
   localparam logic [1:0] TGT_R = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] target;
   } cmd_type;

   typedef struct packed {
      logic busy;       // iterative unit still running
      logic invalid;    // a zero raw denominator
      logic divzero;    // divide by zero-valued b
      logic zero_num;   // numerator or denominator of current target is zero
   } status_type;
endpackage
`default_nettype wire

@@ hdl/rau_datapath.sv @@
// -----------------------------------------------------------------------------
// rau_datapath
// Operand registers, cross multiplier and a shared restoring divider that
// yields one quotient bit per step (used both for gcd remainders and for
// the final reduction).
// -----------------------------------------------------------------------------
`default_nettype none
module rau_datapath #(
   parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire rau_pkg::cmd_type    cmd,
   output rau_pkg::status_type      stat,
   input  wire [1:0]         in_command,
   input  wire [31:0]        in_a_num,
   input  wire [31:0]        in_a_den,
   input  wire [31:0]        in_b_num,
   input  wire [31:0]        in_b_den,
   output logic [31:0]       res_num,
   output logic [30:0]       res_den,
   output logic [1:0]        res_status
);
   import rau_pkg::*;
   localparam logic [WIDE-1:0] LIMIT = WIDE'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

   logic [1:0]      command_ff, command_in;
   logic            a_neg_ff, a_neg_in, b_neg_ff, b_neg_in, r_neg_ff, r_neg_in;
   logic [WIDE-1:0] a_mag_ff, a_mag_in, a_den_ff, a_den_in;
   logic [WIDE-1:0] b_mag_ff, b_mag_in, b_den_ff, b_den_in;
   logic [WIDE-1:0] r_mag_ff, r_mag_in, r_den_ff, r_den_in;
   logic [WIDE-1:0] t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic            inval_ff, inval_in;
   // iterative unit: gcd via repeated remainders, or a plain quotient
   logic            gmode_ff, gmode_in, run_ff, run_in, divd_ff, divd_in;
   logic [WIDE-1:0] x_ff, x_in, y_ff, y_in, q_ff, q_in, rem_ff, rem_in;
   logic [WIDE-1:0] g_ff, g_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic [1:0]      tgt_ff, tgt_in;
   logic [31:0]     rn_ff, rn_in;
   logic [30:0]     rd_ff, rd_in;
   logic [1:0]      rs_ff, rs_in;

   logic [WIDE-1:0] rem_sh, sel_num, sel_den;
   logic            sb;
   logic [32:0]     an, ad, bn, bd;

   function automatic logic [32:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? 33'(33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
   endfunction

   always_comb begin
      unique case (cmd.target)
         TGT_A:   begin sel_num = a_mag_ff; sel_den = a_den_ff; end
         TGT_B:   begin sel_num = b_mag_ff; sel_den = b_den_ff; end
         default: begin sel_num = r_mag_ff; sel_den = r_den_ff; end
      endcase
   end

   always_comb begin
      an = mag32(in_a_num);
      ad = mag32(in_a_den);
      bn = mag32(in_b_num);
      bd = mag32(in_b_den);
      sb = (command_ff == CMD_SUB) ? !b_neg_ff : b_neg_ff;
      if (b_mag_ff == '0) sb = 1'b0;
      rem_sh = {rem_ff[WIDE-2:0], x_ff[WIDE-1]};

      command_in = command_ff;
      a_neg_in = a_neg_ff; a_mag_in = a_mag_ff; a_den_in = a_den_ff;
      b_neg_in = b_neg_ff; b_mag_in = b_mag_ff; b_den_in = b_den_ff;
      r_neg_in = r_neg_ff; r_mag_in = r_mag_ff; r_den_in = r_den_ff;
      t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff;
      inval_in = inval_ff;
      gmode_in = gmode_ff; run_in = run_ff; divd_in = divd_ff;
      x_in = x_ff; y_in = y_ff; q_in = q_ff; rem_in = rem_ff; g_in = g_ff;
      cnt_in = cnt_ff; tgt_in = tgt_ff;
      rn_in = rn_ff; rd_in = rd_ff; rs_in = rs_ff;

      unique case (cmd.op)
         OP_LOAD: begin
            command_in = in_command;
            inval_in = (in_a_den == '0) || (in_b_den == '0);
            a_neg_in = in_a_num[31] ^ in_a_den[31];
            b_neg_in = in_b_num[31] ^ in_b_den[31];
            a_mag_in = WIDE'(an); a_den_in = WIDE'(ad);
            b_mag_in = WIDE'(bn); b_den_in = WIDE'(bd);
         end
         OP_GCD_A, OP_GCD_B, OP_GCD_R: begin
            tgt_in = cmd.op == OP_GCD_A ? TGT_A : cmd.op == OP_GCD_B ? TGT_B : TGT_R;
            unique case (cmd.op)
               OP_GCD_A: begin x_in = a_mag_ff; g_in = a_den_ff; end
               OP_GCD_B: begin x_in = b_mag_ff; g_in = b_den_ff; end
               default:  begin x_in = r_mag_ff; g_in = r_den_ff; end
            endcase
            // y starts as the divisor loaded into g; g takes the gcd when y reaches zero
            y_in = g_in;
            gmode_in = 1'b1; run_in = 1'b1; cnt_in = '0; rem_in = '0; q_in = '0;
         end
         OP_DIVN, OP_DIVD: begin
            x_in = (cmd.op == OP_DIVN) ? sel_num : sel_den;
            y_in = g_ff; divd_in = (cmd.op == OP_DIVD);
            gmode_in = 1'b0; run_in = 1'b1; cnt_in = '0; rem_in = '0; q_in = '0;
         end
         OP_STEP: begin
            if (run_ff) begin
               if (gmode_ff && y_ff == '0) begin
                  g_in = x_ff; run_in = 1'b0;
               end else begin
                  if (rem_sh >= y_ff) begin
                     rem_in = rem_sh - y_ff; q_in = {q_ff[WIDE-2:0], 1'b1};
                  end else begin
                     rem_in = rem_sh; q_in = {q_ff[WIDE-2:0], 1'b0};
                  end
                  x_in = {x_ff[WIDE-2:0], 1'b0};
                  cnt_in = cnt_ff + 7'd1;
                  if (cnt_ff == 7'(WIDE - 1)) begin
                     if (gmode_ff) begin
                        // next remainder pass: (x, y) <- (y, x mod y)
                        x_in = y_ff; y_in = rem_in;
                        rem_in = '0; cnt_in = '0;
                     end else begin
                        run_in = 1'b0;
                        unique case (tgt_ff)
                           TGT_A:   if (divd_ff) a_den_in = q_in; else a_mag_in = q_in;
                           TGT_B:   if (divd_ff) b_den_in = q_in; else b_mag_in = q_in;
                           default: if (divd_ff) r_den_in = q_in; else r_mag_in = q_in;
                        endcase
                     end
                  end
               end
            end
         end
         OP_MUL1: begin
            unique case (command_ff)
               CMD_ADD, CMD_SUB: begin
                  t1_in = WIDE'(a_mag_ff[31:0]) * WIDE'(b_den_ff[31:0]);
                  t2_in = WIDE'(b_mag_ff[31:0]) * WIDE'(a_den_ff[31:0]);
                  t3_in = WIDE'(a_den_ff[31:0]) * WIDE'(b_den_ff[31:0]);
               end
               CMD_MUL: begin
                  t1_in = WIDE'(a_mag_ff[31:0]) * WIDE'(b_mag_ff[31:0]);
                  t3_in = WIDE'(a_den_ff[31:0]) * WIDE'(b_den_ff[31:0]);
               end
               default: begin
                  t1_in = WIDE'(a_mag_ff[31:0]) * WIDE'(b_den_ff[31:0]);
                  t3_in = WIDE'(a_den_ff[31:0]) * WIDE'(b_mag_ff[31:0]);
               end
            endcase
         end
         OP_MUL2: begin
            r_den_in = t3_ff;
            if (command_ff == CMD_ADD || command_ff == CMD_SUB) begin
               if (a_neg_ff == sb) begin
                  r_mag_in = t1_ff + t2_ff; r_neg_in = a_neg_ff;
               end else if (t1_ff >= t2_ff) begin
                  r_mag_in = t1_ff - t2_ff; r_neg_in = a_neg_ff;
               end else begin
                  r_mag_in = t2_ff - t1_ff; r_neg_in = sb;
               end
            end else begin
               r_mag_in = t1_ff; r_neg_in = a_neg_ff ^ b_neg_ff;
            end
         end
         OP_FINISH: begin
            rs_in = ST_OK;
            if (inval_ff) rs_in = ST_INVALID;
            else if (command_ff == CMD_DIV && b_mag_ff == '0) rs_in = ST_DIVZERO;
            else if (r_mag_ff != '0 && (r_mag_ff > LIMIT || r_den_ff > LIMIT))
               rs_in = ST_OVERFLOW;
            if (rs_in != ST_OK || r_mag_ff == '0) begin
               rn_in = '0; rd_in = 31'd1;
            end else begin
               rn_in = r_neg_ff ? 32'(-r_mag_ff[31:0]) : r_mag_ff[31:0];
               rd_in = r_den_ff[30:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      command_ff <= command_in; inval_ff <= inval_in;
      a_neg_ff <= a_neg_in; a_mag_ff <= a_mag_in; a_den_ff <= a_den_in;
      b_neg_ff <= b_neg_in; b_mag_ff <= b_mag_in; b_den_ff <= b_den_in;
      r_neg_ff <= r_neg_in; r_mag_ff <= r_mag_in; r_den_ff <= r_den_in;
      t1_ff <= t1_in; t2_ff <= t2_in; t3_ff <= t3_in;
      gmode_ff <= gmode_in; divd_ff <= divd_in;
      x_ff <= x_in; y_ff <= y_in; q_ff <= q_in; rem_ff <= rem_in; g_ff <= g_in;
      cnt_ff <= cnt_in; tgt_ff <= tgt_in;
      rn_ff <= rn_in; rd_ff <= rd_in; rs_ff <= rs_in;
   end

   always_comb begin
      stat.busy     = run_ff;
      stat.invalid  = inval_ff;
      stat.divzero  = (command_ff == CMD_DIV) && (b_mag_ff == '0);
      stat.zero_num = (sel_num == '0) || (sel_den == '0);
   end

   assign res_num = rn_ff;
   assign res_den = rd_ff;
   assign res_status = rs_ff;
endmodule
`default_nettype wire

@@ hdl/rau_control.sv @@
// -----------------------------------------------------------------------------
// rau_control
// Sequencer: load, reduce a, reduce b, multiply, combine, reduce result,
// format, then hold the result beat until taken.
// -----------------------------------------------------------------------------
`default_nettype none
module rau_control (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_fire,
   input  wire                  rsp_fire,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output rau_pkg::cmd_type     cmd,
   input  wire rau_pkg::status_type stat
);
   import rau_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_GCD = 4'd1, S_GWAIT = 4'd2, S_DIVN = 4'd3,
      S_NWAIT = 4'd4, S_DIVD = 4'd5, S_DWAIT = 4'd6, S_MUL1 = 4'd7, S_MUL2 = 4'd8,
      S_FIN = 4'd9, S_OUT = 4'd10, S_NEXT = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] tgt_ff, tgt_in;

   always_comb begin
      state_in = state_ff; tgt_in = tgt_ff;
      cmd.op = OP_NONE; cmd.target = tgt_ff;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_OUT);
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            cmd.op = OP_LOAD; tgt_in = TGT_A; state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.invalid) state_in = S_FIN;
            else if (stat.zero_num) state_in = S_NEXT;
            else begin
               cmd.op = (tgt_ff == TGT_A) ? OP_GCD_A : (tgt_ff == TGT_B) ? OP_GCD_B : OP_GCD_R;
               state_in = S_GWAIT;
            end
         end
         S_GWAIT: begin cmd.op = OP_STEP; if (!stat.busy) state_in = S_DIVN; end
         S_DIVN:  begin cmd.op = OP_DIVN; state_in = S_NWAIT; end
         S_NWAIT: begin cmd.op = OP_STEP; if (!stat.busy) state_in = S_DIVD; end
         S_DIVD:  begin cmd.op = OP_DIVD; state_in = S_DWAIT; end
         S_DWAIT: begin cmd.op = OP_STEP; if (!stat.busy) state_in = S_NEXT; end
         S_NEXT: begin
            if (tgt_ff == TGT_A) begin tgt_in = TGT_B; state_in = S_GCD; end
            else if (tgt_ff == TGT_B) state_in = S_MUL1;
            else state_in = S_FIN;
         end
         S_MUL1: begin
            if (stat.divzero) state_in = S_FIN;
            else begin cmd.op = OP_MUL1; state_in = S_MUL2; end
         end
         S_MUL2: begin cmd.op = OP_MUL2; tgt_in = TGT_R; state_in = S_GCD; end
         S_FIN:  begin cmd.op = OP_FINISH; state_in = S_OUT; end
         S_OUT:  if (rsp_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; tgt_ff <= TGT_A;
      end else begin
         state_ff <= state_in; tgt_ff <= tgt_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/rational_arithmetic_unit.sv @@
// -----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/subtract/multiply/divide of two fractions with gcd reduction.
// -----------------------------------------------------------------------------
// One command at a time: a beat ends early on a zero denominator and otherwise
// its length is set by the shared one-bit-per-cycle divider: one full
// 64-bit remainder pass for each Euclid gcd step (up to about 46 passes
// for a and for b, about 92 for the 64-bit result) plus two reduction
// quotients for each of a, b and the result.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
   parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,  // a_num, a_den, b_num, b_den
   input  wire  [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,  // res_num, res_den, zero pad
   output logic [1:0]   rsp_tuser   // status
);
   import rau_pkg::*;
   cmd_type    cmd;
   status_type stat;
   logic [31:0] rn;
   logic [30:0] rd;
   logic [1:0]  rs;
   wire req_fire = req_tvalid && req_tready;
   wire rsp_fire = rsp_tvalid && rsp_tready;

   rau_control u_ctl (.clock, .reset, .req_fire, .rsp_fire, .req_ready(req_tready),
      .rsp_valid(rsp_tvalid), .cmd, .stat);

   rau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (.clock, .reset, .cmd, .stat,
      .in_command(req_tuser), .in_a_num(req_tdata[31:0]), .in_a_den(req_tdata[63:32]),
      .in_b_num(req_tdata[95:64]), .in_b_den(req_tdata[127:96]),
      .res_num(rn), .res_den(rd), .res_status(rs));

   assign rsp_tdata = {1'b0, rd, rn};
   assign rsp_tuser = rs;

   `RAU_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready,
      "input accepted while result pending")
   `RAU_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_OK,
      rsp_tdata[31:0] == 32'd0 && rsp_tdata[62:32] == 31'd1, "error result not 0/1")
   `RAU_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, !req_tready,
      "ready stayed high after accept")
endmodule
`default_nettype wire
